// ----- src/etc_pkg.sv -----
// shared types, constants and calendar helpers for the timestamp converter
package etc_pkg;

    localparam logic [24:0] SecNormalYear = 25'd31536000;
    localparam logic [24:0] SecLeapYear   = 25'd31622400;
    localparam logic [29:0] NsMax         = 30'd999999999;
    localparam logic [11:0] BaseYear      = 12'd2000;
    localparam logic [11:0] EpochYear     = 12'd1990;

    // configuration register indexes
    localparam logic CfgZone = 1'b0;
    localparam logic CfgTick = 1'b1;

    // item handed from the front stages to the date split stages
    typedef struct packed {
        logic [11:0] year;
        logic        leap;
        logic [24:0] us;
        logic [5:0]  second;
        logic [29:0] ns;
    } etc_mid_t;

    // result item as it moves down the back stages
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [32:0] since;
        logic [29:0] ns;
    } etc_out_t;

    // gregorian rule over 1999..2128: only 2100 is a skipped century
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != 12'd2100);
    endfunction

    function automatic logic [24:0] year_secs(input logic [11:0] y);
        return is_leap(y) ? SecLeapYear : SecNormalYear;
    endfunction

    // first day of year of month m, m = 12 gives the year length
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        if (leap && (m >= 4'd2))
        begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

// ----- src/etc_front.sv -----
// front stages: unpack, seconds of year with zone offset, year carry, nanoseconds
module etc_front (
    input  logic                  clk,
    input  logic [1:0]            en,
    input  logic [31:0]           stamp_hi,
    input  logic [31:0]           stamp_lo,
    input  logic [16:0]           zone,
    input  logic [31:0]           tick_period,
    output etc_pkg::etc_mid_t     mid
);

    logic [8:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  ms;
    logic [20:0] tick;
    logic [26:0] pos_secs;

    logic [26:0] s1_secs_reg,  s1_secs_next;
    logic [11:0] s1_year_reg,  s1_year_next;
    logic [5:0]  s1_sec_reg,   s1_sec_next;
    logic [29:0] s1_msns_reg,  s1_msns_next;
    logic [52:0] s1_prod_reg,  s1_prod_next;

    etc_pkg::etc_mid_t mid_reg, mid_next;

    logic [24:0] ysec_cur;
    logic [24:0] ysec_prev;
    logic [11:0] year_adj;
    logic [37:0] ns_sum;

    assign day    = stamp_hi[31:23];
    assign hour   = stamp_hi[16:12];
    assign minute = stamp_hi[11:6];
    assign second = stamp_hi[5:0];
    assign ms     = stamp_lo[30:21];
    assign tick   = stamp_lo[20:0];

    always_comb
    begin
        pos_secs = 27'(day) * 27'd86400 + 27'(hour) * 27'd3600
                 + 27'(minute) * 27'd60 + 27'(second);
        // two's complement sum, bit 26 is the sign
        s1_secs_next = pos_secs - 27'd86400 + {{10{zone[16]}}, zone};
        s1_year_next = etc_pkg::BaseYear + 12'({stamp_lo[31], stamp_hi[22:17]});
        s1_sec_next  = (second > 6'd59) ? 6'd59 : second;
        s1_msns_next = 30'(ms) * 30'd1000000;
        s1_prod_next = 53'(tick) * 53'(tick_period);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_secs_reg <= s1_secs_next;
            s1_year_reg <= s1_year_next;
            s1_sec_reg  <= s1_sec_next;
            s1_msns_reg <= s1_msns_next;
            s1_prod_reg <= s1_prod_next;
        end
    end

    always_comb
    begin
        ysec_cur  = etc_pkg::year_secs(s1_year_reg);
        ysec_prev = etc_pkg::year_secs(s1_year_reg - 12'd1);
        year_adj  = s1_year_reg;
        mid_next.us = s1_secs_reg[24:0];
        if (s1_secs_reg[26])
        begin
            year_adj    = s1_year_reg - 12'd1;
            mid_next.us = 25'(s1_secs_reg + 27'(ysec_prev));
        end
        else if (s1_secs_reg >= 27'(ysec_cur))
        begin
            year_adj    = s1_year_reg + 12'd1;
            mid_next.us = 25'(s1_secs_reg - 27'(ysec_cur));
        end
        mid_next.year   = year_adj;
        mid_next.leap   = etc_pkg::is_leap(year_adj);
        mid_next.second = s1_sec_reg;
        ns_sum = 38'(s1_msns_reg) + 38'(s1_prod_reg[52:16]);
        mid_next.ns = (ns_sum > 38'(etc_pkg::NsMax)) ? etc_pkg::NsMax : ns_sum[29:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

// ----- src/etc_split.sv -----
// back stages: day of year, month lookup, hour and minute split, epoch seconds
module etc_split (
    input  logic                  clk,
    input  logic [4:0]            en,
    input  etc_pkg::etc_mid_t     mid,
    output etc_pkg::etc_out_t     result
);

    // stage 3
    etc_pkg::etc_mid_t s3_mid_reg;
    logic [8:0]  s3_yday_reg, s3_yday_next;
    logic [15:0] s3_days_reg, s3_days_next;
    logic [38:0] yprod;
    logic [7:0]  yoff;

    // stage 4
    etc_pkg::etc_out_t s4_out_reg, s4_out_next;
    logic [24:0] s4_us_reg;
    logic [16:0] s4_rem_reg, s4_rem_next;
    logic [24:0] day_secs;
    logic [8:0]  mstart;
    logic [8:0]  mday_full;

    // stage 5
    etc_pkg::etc_out_t s5_out_reg, s5_out_next;
    logic [16:0] s5_rem_reg;
    logic [25:0] hprod;

    // stage 6
    etc_pkg::etc_out_t s6_out_reg;
    logic [11:0] s6_r2_reg, s6_r2_next;

    // stage 7
    etc_pkg::etc_out_t out_reg, out_next;
    logic [24:0] mprod;

    always_comb
    begin
        // us / 86400 as (us >> 7) / 675 by exact reciprocal
        yprod = 39'(mid.us[24:7]) * 39'd1590729;
        s3_yday_next = yprod[38:30];
        yoff = 8'(mid.year - etc_pkg::EpochYear);
        s3_days_next = 16'(yoff) * 16'd365 + 16'((9'(yoff) + 9'd1) >> 2)
                     - 16'(mid.year > 12'd2100);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s3_mid_reg  <= mid;
            s3_yday_reg <= s3_yday_next;
            s3_days_reg <= s3_days_next;
        end
    end

    always_comb
    begin
        day_secs = 25'(s3_yday_reg) * 25'd86400;
        s4_rem_next = 17'(s3_mid_reg.us - day_secs);
        s4_out_next = '0;
        s4_out_next.year   = s3_mid_reg.year;
        s4_out_next.second = s3_mid_reg.second;
        s4_out_next.ns     = s3_mid_reg.ns;
        s4_out_next.month  = 4'd11;
        // first month whose end lies beyond the day of year
        for (int m = 11; m >= 0; m--)
        begin
            if (s3_yday_reg < etc_pkg::month_start(s3_mid_reg.leap, 4'(m + 1)))
            begin
                s4_out_next.month = 4'(m);
            end
        end
        mstart = etc_pkg::month_start(s3_mid_reg.leap, s4_out_next.month);
        mday_full = s3_yday_reg - mstart + 9'd1;
        s4_out_next.mday  = (mday_full > 9'd31) ? 5'd31 : mday_full[4:0];
        s4_out_next.since = 33'(s3_days_reg) * 33'd86400;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s4_out_reg <= s4_out_next;
            s4_us_reg  <= s3_mid_reg.us;
            s4_rem_reg <= s4_rem_next;
        end
    end

    always_comb
    begin
        // rem / 3600 as (rem >> 4) / 225
        hprod = 26'(s4_rem_reg[16:4]) * 26'd4661;
        s5_out_next = s4_out_reg;
        s5_out_next.hour  = hprod[24:20];
        s5_out_next.since = s4_out_reg.since + 33'(s4_us_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s5_out_reg <= s5_out_next;
            s5_rem_reg <= s4_rem_reg;
        end
    end

    assign s6_r2_next = 12'(s5_rem_reg - 17'(s5_out_reg.hour) * 17'd3600);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s6_out_reg <= s5_out_reg;
            s6_r2_reg  <= s6_r2_next;
        end
    end

    always_comb
    begin
        mprod = 25'(s6_r2_reg) * 25'd4370;
        out_next = s6_out_reg;
        out_next.minute = mprod[23:18];
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            out_reg <= out_next;
        end
    end

    assign result = out_reg;

endmodule

// ----- src/event_timestamp_to_calendar.sv -----
// top level of the event timestamp to calendar converter
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata, one packed event stamp
//   per beat (high stamp word in bits 31:0, low stamp word in bits 63:32).
//   Each beat yields exactly one result beat on m_tvalid/m_tready/m_tdata
//   with year, month, day, hour, minute, second, seconds since 1990 UTC and
//   nanoseconds within the second.
//   Zone offset (index 0) and tick period (index 1) are set through cfg_we,
//   cfg_idx and cfg_wdata while no beat is in flight.
// Timing:
//   Seven register stages lie between an input beat and its result beat.
//   Throughput is one beat per cycle, every stage takes a new beat each
//   cycle while the output is drained.
// Reset:
//   rst_n clears all stage valid bits and both registers to zero.
// Backpressure:
//   Each stage holds its beat while the next is full and stalled; bubbles close up, so
//   s_tready stays high until all seven stages are occupied and m_tready low.
module event_timestamp_to_calendar (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // stamp_word_high, stamp_word_low
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,   // year_full, month_index, day_of_month, hour_of_day,
                                     // minute_of_hour, second_of_minute,
                                     // seconds_since_1990, nanoseconds, zero pad
    input  logic          cfg_we,
    input  logic          cfg_idx,
    input  logic [31:0]   cfg_wdata
);

    logic [16:0] zone_reg;
    logic [31:0] tick_reg;
    logic [7:1]  valid_reg, valid_next;
    logic [8:1]  en;

    etc_pkg::etc_mid_t mid;
    etc_pkg::etc_out_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
            tick_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                etc_pkg::CfgZone: zone_reg <= cfg_wdata[16:0];
                etc_pkg::CfgTick: tick_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its beat moves on
    always_comb
    begin
        en[8] = m_tready;
        for (int i = 7; i >= 1; i--)
        begin
            en[i] = !valid_reg[i] || en[i + 1];
        end
        valid_next[1] = en[1] ? s_tvalid : valid_reg[1];
        for (int i = 2; i <= 7; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    etc_front u_front (
        .clk         (clk),
        .en          (en[2:1]),
        .stamp_hi    (s_tdata[31:0]),
        .stamp_lo    (s_tdata[63:32]),
        .zone        (zone_reg),
        .tick_period (tick_reg),
        .mid         (mid)
    );

    etc_split u_split (
        .clk    (clk),
        .en     (en[7:3]),
        .mid    (mid),
        .result (result)
    );

    assign s_tready = en[1];
    assign m_tvalid = valid_reg[7];
    assign m_tdata  = {3'b000, result.ns, result.since, result.second, result.minute,
                       result.hour, result.mday, result.month, result.year};

endmodule

// ----- src/etc_checker.sv -----
// port level checks for the timestamp converter, bound to the top level
module etc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [103:0]  m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_month_day: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:12] <= 4'd11) && (m_tdata[20:16] != 5'd0))
        else $error("month or day of month out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[25:21] <= 5'd23) && (m_tdata[31:26] <= 6'd59)
                     && (m_tdata[37:32] <= 6'd59))
        else $error("hour, minute or second out of range");

    a_ns_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[100:71] <= 30'd999999999) && (m_tdata[103:101] == 3'b000))
        else $error("nanoseconds above saturation limit");

    a_full_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

endmodule

bind event_timestamp_to_calendar etc_checker u_etc_checker (.*);
